/* rtl/sgcr_pkg.sv */
package sgcr_pkg;

  localparam int COL_W   = 7;
  localparam int PAGE_W  = 3;
  localparam int CNT_W   = 3;
  localparam int BITS_W  = 32;
  localparam int IN_W    = 26;
  localparam int OUT_W   = COL_W + PAGE_W + CNT_W + BITS_W;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd100;
  localparam logic [2:0] GLYPH_COLS = 3'd5;
  localparam int         NUM_GLYPHS = 69;

  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  typedef struct packed {
    logic load_draw;
    logic load_set;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_col;
  } status_t;

  // One glyph per row, font column 0 in the low byte.
  localparam logic [39:0] GLYPH_ROM [NUM_GLYPHS] = '{
    40'h00_00_00_00_00, 40'h00_00_2F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h12_2A_7F_2A_24, 40'h23_13_08_64_62, 40'h50_22_55_49_36, 40'h00_00_03_05_00,
    40'h00_41_22_1C_00, 40'h00_1C_22_41_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_60_A0_00_00, 40'h08_08_08_08_08, 40'h00_00_60_60_00, 40'h02_04_08_10_20,
    40'h3E_45_49_51_3E, 40'h00_40_7F_42_00, 40'h46_49_51_61_42, 40'h31_4B_45_41_21,
    40'h10_7F_12_14_18, 40'h39_45_45_45_27, 40'h30_49_49_4A_3C, 40'h03_05_09_71_01,
    40'h36_49_49_49_36, 40'h1E_29_49_49_06, 40'h00_00_36_36_00, 40'h00_00_36_56_00,
    40'h00_41_22_14_08, 40'h14_14_14_14_14, 40'h08_14_22_41_00, 40'h06_09_51_01_02,
    40'h3E_51_59_49_32, 40'h7C_12_11_12_7C, 40'h36_49_49_49_7F, 40'h22_41_41_41_3E,
    40'h1C_22_41_41_7F, 40'h41_49_49_49_7F, 40'h01_09_09_09_7F, 40'h7A_49_49_41_3E,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h01_3F_41_40_20, 40'h41_22_14_08_7F,
    40'h40_40_40_40_7F, 40'h7F_02_0C_02_7F, 40'h7F_10_08_04_7F, 40'h3E_41_41_41_3E,
    40'h06_09_09_09_7F, 40'h5E_21_51_41_3E, 40'h46_29_19_09_7F, 40'h31_49_49_49_46,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h43_45_49_51_61, 40'h00_41_41_7F_00,
    40'h20_10_08_04_02, 40'h00_7F_41_41_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h38_38_38_38_38, 40'hFF_FF_FF_FF_FF, 40'hFF_FF_FF_FF_FF, 40'hFF_FF_FF_FF_FF,
    40'hFF_FF_FF_FF_FF
  };

endpackage

/* rtl/sgcr_ctrl.sv */
module sgcr_ctrl
  import sgcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_tuser,
  output logic    s_tready,
  input  logic    m_tready,
  output logic    m_tvalid,
  output cmd_t    cmd,
  input  status_t stat
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t state;
  logic   s_fire;

  assign s_tready = (state == IDLE);
  assign s_fire   = s_tvalid && s_tready;

  always_comb begin
    cmd.load_draw = s_fire && (s_tuser == REQ_DRAW);
    cmd.load_set  = s_fire && (s_tuser == REQ_SET);
    cmd.emit      = (state == RUN) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.load_draw) begin
            state <= RUN;
          end
        end
        RUN: begin
          // the final column leaves the sequencer; output register keeps it
          if (cmd.emit && stat.last_col) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/sgcr_datapath.sv */
module sgcr_datapath
  import sgcr_pkg::*;
#(
  parameter int PAGES      = 8,
  parameter int COLUMNS    = 128,
  parameter int CHAR_PITCH = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_W-1:0]   in_data,
  input  cmd_t              cmd,
  output status_t           stat,
  output logic [COL_W-1:0]  column_addr,
  output logic [PAGE_W-1:0] first_page,
  output logic [CNT_W-1:0]  page_count,
  output logic [BITS_W-1:0] column_bits,
  output logic              last
);

  // Constant-modulus reduction by shifted compare and subtract.
  function automatic logic [7:0] reduce_mod(input logic [7:0] v, input int m);
    logic [15:0] t;
    logic [15:0] step;
    t = 16'(v);
    for (int k = 6; k >= 0; k--) begin
      step = 16'(m) << k;
      if (t >= step) begin
        t = t - step;
      end
    end
    return t[7:0];
  endfunction

  // Each bit repeated fm1+1 times.
  function automatic logic [31:0] stretch(input logic [7:0] b, input logic [1:0] fm1);
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
    logic [31:0] w;
    w1 = '0;
    w2 = '0;
    w3 = '0;
    for (int j = 0; j < 8; j++) begin
      w1[j]         = b[j];
      w2[2*j +: 2]  = {2{b[j]}};
      w3[3*j +: 3]  = {3{b[j]}};
      w4[4*j +: 4]  = {4{b[j]}};
    end
    case (fm1)
      2'd0:    w = w1;
      2'd1:    w = w2;
      2'd2:    w = w3;
      default: w = w4;
    endcase
    return w;
  endfunction

  logic [7:0]        char_code;
  logic [1:0]        size_sel;
  logic [7:0]        new_column;
  logic [7:0]        new_page;

  logic [COL_W-1:0]  cursor_column;
  logic [PAGE_W-1:0] cursor_page;
  logic [39:0]       glyph;
  logic [1:0]        scale_m1;
  logic [2:0]        gcol;
  logic [1:0]        rep;
  logic [COL_W-1:0]  col;

  logic [6:0]        rom_idx;
  logic [7:0]        glyph_byte;
  logic [BITS_W-1:0] bits_now;
  logic [7:0]        adv_sum;
  logic [7:0]        adv_step;
  logic [COL_W-1:0]  col_next;
  logic [7:0]        cur_col_mod;
  logic [7:0]        cur_page_mod;

  assign char_code  = in_data[7:0];
  assign size_sel   = in_data[9:8];
  assign new_column = in_data[17:10];
  assign new_page   = in_data[25:18];

  assign rom_idx = (char_code < FIRST_CODE || char_code > LAST_CODE) ? 7'd0
                 : 7'(char_code - FIRST_CODE);

  assign glyph_byte = (gcol < GLYPH_COLS) ? glyph[{gcol, 3'b000} +: 8] : 8'd0;
  assign bits_now   = stretch(glyph_byte, scale_m1);

  assign stat.last_col = (gcol == GLYPH_COLS) && (rep == scale_m1);

  assign col_next = (col == COL_W'(COLUMNS - 1)) ? '0 : col + 1'b1;

  // f * pitch is at most 24 and the cursor below 128, so one wrap suffices
  assign adv_step = 8'(({6'd0, scale_m1} + 8'd1) * 8'(CHAR_PITCH));
  assign adv_sum  = {1'b0, cursor_column} + adv_step;

  assign cur_col_mod  = reduce_mod(new_column, COLUMNS);
  assign cur_page_mod = reduce_mod(new_page, PAGES);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_page   <= '0;
    end else if (cmd.load_set) begin
      cursor_column <= cur_col_mod[COL_W-1:0];
      cursor_page   <= cur_page_mod[PAGE_W-1:0];
    end else if (cmd.emit && stat.last_col) begin
      if (adv_sum >= 8'(COLUMNS)) begin
        cursor_column <= COL_W'(adv_sum - 8'(COLUMNS));
      end else begin
        cursor_column <= adv_sum[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gcol <= '0;
      rep  <= '0;
    end else if (cmd.load_draw) begin
      gcol <= '0;
      rep  <= '0;
    end else if (cmd.emit) begin
      if (rep == scale_m1) begin
        rep  <= '0;
        gcol <= gcol + 1'b1;
      end else begin
        rep <= rep + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_draw) begin
      glyph    <= GLYPH_ROM[rom_idx];
      scale_m1 <= size_sel;
      col      <= cursor_column;
    end else if (cmd.emit) begin
      col <= col_next;
    end
    if (cmd.emit) begin
      column_addr <= col;
      first_page  <= cursor_page;
      page_count  <= {1'b0, scale_m1} + 3'd1;
      column_bits <= bits_now;
      last        <= stat.last_col;
    end
  end

endmodule

/* rtl/scaled_glyph_column_renderer.sv */
// Draws one character of the built-in 5x8 font at scale f = size_sel+1 as 6f column
// writes, one every cycle while the output side takes them: 5f stretched glyph columns
// and f blank ones, column-major, with the column address wrapping at COLUMNS. A draw
// request holds off the input until its final column leaves the column sequencer in the
// datapath; a set-cursor request does not occupy the sequencer and gives no result. The next
// request is taken while the final column still waits in the output register.
module scaled_glyph_column_renderer
  import sgcr_pkg::*;
#(
  parameter int PAGES      = 8,
  parameter int COLUMNS    = 128,
  parameter int CHAR_PITCH = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code[7:0], size_sel[9:8], new_column[17:10],
                                 // new_page[25:18], zero pad
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // column_addr[6:0], first_page[9:7], page_count[12:10],
                                 // column_bits[44:13], zero pad
  output logic        m_tlast    // last
);

  cmd_t              cmd;
  status_t           stat;
  logic [COL_W-1:0]  column_addr;
  logic [PAGE_W-1:0] first_page;
  logic [CNT_W-1:0]  page_count;
  logic [BITS_W-1:0] column_bits;

  sgcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd),
    .stat     (stat)
  );

  sgcr_datapath #(
    .PAGES      (PAGES),
    .COLUMNS    (COLUMNS),
    .CHAR_PITCH (CHAR_PITCH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (s_tdata[IN_W-1:0]),
    .cmd         (cmd),
    .stat        (stat),
    .column_addr (column_addr),
    .first_page  (first_page),
    .page_count  (page_count),
    .column_bits (column_bits),
    .last        (m_tlast)
  );

  assign m_tdata = {3'b000, column_bits, page_count, first_page, column_addr};

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[12:10] != 3'd0 && m_tdata[12:10] <= 3'd4))
    else $error("page_count out of range");

  a_bits_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[44:13] >> {m_tdata[12:10], 3'b000}) == 32'd0))
    else $error("column_bits set above 8*scale");

  a_busy_after_draw: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == REQ_DRAW) |=> !s_tready)
    else $error("draw request did not occupy the sequencer");

  a_emit_when_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result emitted over a waiting result");

endmodule

/* tb/glyph_column_checker.sv */
module glyph_column_checker
  import sgcr_pkg::*;
#(
  parameter int PAGES      = 8,
  parameter int COLUMNS    = 128,
  parameter int CHAR_PITCH = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tlast,
  output int          errors,
  output int          writes_left
);

  typedef struct packed {
    logic [6:0]  column_addr;
    logic [2:0]  first_page;
    logic [2:0]  page_count;
    logic [31:0] column_bits;
    logic        last;
  } col_write_t;

  // Font columns, column 0 in the top byte, codes 32..100.
  localparam logic [39:0] FONT [69] = '{
    40'h00_00_00_00_00, 40'h00_00_2F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h62_64_08_13_23, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_00_A0_60_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_59_51_3E, 40'h7C_12_11_12_7C, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h38_38_38_38_38, 40'hFF_FF_FF_FF_FF, 40'hFF_FF_FF_FF_FF, 40'hFF_FF_FF_FF_FF,
    40'hFF_FF_FF_FF_FF
  };

  col_write_t column_writes_due [$];
  col_write_t want;
  int         cursor_col;
  int         cursor_page;
  int         bad;

  // Each bit j of b fills bits j*f .. j*f+f-1.
  function automatic logic [31:0] stretch_byte(logic [7:0] b, int f);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 8; j++) begin
      for (int r = 0; r < f; r++) begin
        if (b[j]) w[j * f + r] = 1'b1;
      end
    end
    return w;
  endfunction

  task automatic render_glyph(logic [7:0] code, logic [1:0] size_sel);
    int         f;
    int         glyph;
    col_write_t cw;
    f     = size_sel + 1;
    glyph = (code < 8'd32 || code > 8'd100) ? 0 : code - 8'd32;
    for (int n = 0; n < 6 * f; n++) begin
      cw.column_addr = 7'((cursor_col + n) % COLUMNS);
      cw.first_page  = 3'(cursor_page);
      cw.page_count  = 3'(f);
      cw.column_bits = (n < 5 * f) ? stretch_byte(FONT[glyph][39 - 8 * (n / f) -: 8], f) : '0;
      cw.last        = (n == 6 * f - 1);
      column_writes_due.push_back(cw);
    end
    cursor_col = (cursor_col + f * CHAR_PITCH) % COLUMNS;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      column_writes_due.delete();
      cursor_col  = 0;
      cursor_page = 0;
      errors      <= 0;
      writes_left <= 0;
    end else begin
      bad = 0;
      if (s_tvalid && s_tready) begin
        if (s_tuser == REQ_SET) begin
          cursor_col  = s_tdata[17:10] % COLUMNS;
          cursor_page = s_tdata[25:18] % PAGES;
        end else begin
          render_glyph(s_tdata[7:0], s_tdata[9:8]);
        end
      end
      if (m_tvalid && m_tready) begin
        if (column_writes_due.size() == 0) begin
          $display("%0t: unexpected column write, expected none, got column %0d bits %h",
                   $time, m_tdata[6:0], m_tdata[44:13]);
          bad++;
        end else begin
          want = column_writes_due.pop_front();
          if (m_tdata[6:0] !== want.column_addr) begin
            $display("%0t: column_addr mismatch, expected %0d, got %0d",
                     $time, want.column_addr, m_tdata[6:0]);
            bad++;
          end
          if (m_tdata[9:7] !== want.first_page) begin
            $display("%0t: first_page mismatch, expected %0d, got %0d",
                     $time, want.first_page, m_tdata[9:7]);
            bad++;
          end
          if (m_tdata[12:10] !== want.page_count) begin
            $display("%0t: page_count mismatch, expected %0d, got %0d",
                     $time, want.page_count, m_tdata[12:10]);
            bad++;
          end
          if (m_tdata[44:13] !== want.column_bits) begin
            $display("%0t: column_bits mismatch, expected %h, got %h",
                     $time, want.column_bits, m_tdata[44:13]);
            bad++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last mismatch, expected %0d, got %0d", $time, want.last, m_tlast);
            bad++;
          end
          if (m_tdata[47:45] !== 3'b000) begin
            $display("%0t: tdata pad mismatch, expected 0, got %0d", $time, m_tdata[47:45]);
            bad++;
          end
        end
      end
      errors      <= errors + bad;
      writes_left <= column_writes_due.size();
    end
  end

endmodule

/* tb/tb_scaled_glyph_column_renderer.sv */
module tb_scaled_glyph_column_renderer;
  import sgcr_pkg::*;

  localparam int PAGES      = 8;
  localparam int COLUMNS    = 128;
  localparam int CHAR_PITCH = 6;
  localparam int N_RANDOM   = 430;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = 40;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // char_code[7:0], size_sel[9:8], new_column[17:10], new_page[25:18]
  logic        s_tuser;   // req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // column_addr[6:0], first_page[9:7], page_count[12:10],
                          // column_bits[44:13]
  logic        m_tlast;   // last
  int          errors;
  int          writes_left;
  int          cycles;
  int          hold_asks = 0;
  int          hold_done = 0;

  scaled_glyph_column_renderer #(
    .PAGES(PAGES), .COLUMNS(COLUMNS), .CHAR_PITCH(CHAR_PITCH)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  glyph_column_checker #(
    .PAGES(PAGES), .COLUMNS(COLUMNS), .CHAR_PITCH(CHAR_PITCH)
  ) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .errors(errors), .writes_left(writes_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_req(logic req, logic [7:0] code, logic [1:0] size_sel,
                          logic [7:0] col, logic [7:0] page, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {6'b0, page, col, size_sel, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain(int settle);
    s_tvalid <= 1'b0;
    while (writes_left != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Output side: random backpressure, ready stretches, and one long hold on request.
  initial begin
    int g;
    int run_free;
    m_tready = 1'b0;
    run_free = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_asks != hold_done) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_done++;
      end else if (run_free > 0) begin
        m_tready <= 1'b1;
        run_free--;
        @(negedge clk);
      end else begin
        if ($urandom_range(0, 99) < 3) run_free = $urandom_range(20, 80);
        g = pick_gap();
        m_tready <= (g == 0);
        repeat ((g == 0) ? 1 : g) @(negedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic       is_set;
    logic [7:0] code;
    logic [1:0] size_sel;
    logic [7:0] col;
    logic [7:0] page;
    int         gap;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_DRAW;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset cursor, out-of-font codes, range edges, masking, wrap
    send_req(REQ_DRAW, 8'd65,  2'd0, 8'h00, 8'h00, 0);
    send_req(REQ_DRAW, 8'd0,   2'd3, 8'hFF, 8'hFF, pick_gap());
    send_req(REQ_DRAW, 8'd255, 2'd1, 8'h00, 8'h00, pick_gap());
    send_req(REQ_DRAW, 8'd31,  2'd2, 8'h00, 8'h00, pick_gap());
    send_req(REQ_DRAW, 8'd32,  2'd0, 8'h00, 8'h00, pick_gap());
    send_req(REQ_DRAW, 8'd100, 2'd3, 8'h00, 8'h00, pick_gap());
    send_req(REQ_DRAW, 8'd101, 2'd2, 8'h00, 8'h00, pick_gap());
    send_req(REQ_SET,  8'hFF,  2'd3, 8'hFF, 8'hFF, pick_gap());
    send_req(REQ_DRAW, 8'd48,  2'd3, 8'h00, 8'h00, pick_gap());
    send_req(REQ_SET,  8'h00,  2'd0, 8'h00, 8'h00, pick_gap());
    send_req(REQ_DRAW, 8'd33,  2'd0, 8'h00, 8'h00, pick_gap());
    send_req(REQ_SET,  8'hFF,  2'd3, 8'd120, 8'd9, pick_gap());
    send_req(REQ_DRAW, 8'd87,  2'd3, 8'h00, 8'h00, pick_gap());
    send_req(REQ_DRAW, 8'd64,  2'd2, 8'hAA, 8'h55, pick_gap());
    send_req(REQ_DRAW, 8'd99,  2'd0, 8'h55, 8'hAA, pick_gap());
    send_req(REQ_SET,  8'h00,  2'd0, 8'd128, 8'd8, pick_gap());
    send_req(REQ_DRAW, 8'd44,  2'd1, 8'h00, 8'h00, pick_gap());
    send_req(REQ_SET,  8'h00,  2'd0, 8'd127, 8'd7, pick_gap());
    send_req(REQ_DRAW, 8'd66,  2'd1, 8'h00, 8'h00, 0);
    send_req(REQ_DRAW, 8'd67,  2'd1, 8'h00, 8'h00, 0);
    drain(SETTLE);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 150) hold_asks++;
      if (i == 280) drain(SETTLE);
      is_set   = ($urandom_range(0, 99) < 15);
      code     = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(32, 100))
                                              : 8'($urandom_range(0, 255));
      size_sel = 2'($urandom_range(0, 3));
      col      = 8'($urandom_range(0, 255));
      page     = 8'($urandom_range(0, 255));
      gap      = (i >= 320 && i < 380) ? 0 : pick_gap();
      send_req(is_set ? REQ_SET : REQ_DRAW, code, size_sel, col, page, gap);
    end
    drain(SETTLE);

    if (errors == 0 && writes_left == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* scaled_glyph_column_renderer.f */
rtl/sgcr_pkg.sv
rtl/sgcr_ctrl.sv
rtl/sgcr_datapath.sv
rtl/scaled_glyph_column_renderer.sv
tb/glyph_column_checker.sv
tb/tb_scaled_glyph_column_renderer.sv
